@@ rtl/rgbc_pkg.sv @@
// Shared constants, types and the result finishing function of the RGB 3x3 filter.
// Used by every module of the block but rgbc_ram; depends on nothing.
package rgbc_pkg;

   localparam int IMG_WIDTH_DEF  = 64;
   localparam int IMG_HEIGHT_DEF = 48;

   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int TAPS      = 9;
   localparam int WEIGHT_W  = 5;
   localparam int KERNEL_W  = TAPS * WEIGHT_W;
   localparam int SHIFT_W   = 4;
   localparam int PROD_W    = 13;
   localparam int SUM_W     = 17;
   localparam int POS_W     = 6;
   localparam int CHANNELS  = 3;

   localparam logic [KERNEL_W-1:0] KERNEL_RESET = 45'd1134979744801;
   localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd3;
   localparam logic [SUM_W-1:0]    OUT_MAX      = SUM_W'(255);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic REG_KERNEL = 1'b0;
   localparam logic REG_SHIFT  = 1'b1;

   typedef logic [RGB_W-1:0] rgb_type;
   typedef rgb_type [TAPS-1:0] rgb_taps_type;
   typedef logic [TAPS-1:0][PIX_W-1:0] chan_taps_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic prod;
      logic sum;
   } stage_en_type;

   function automatic logic [PIX_W-1:0] finish_sum(logic signed [SUM_W-1:0] s,
                                                   logic [SHIFT_W-1:0] k);
      logic signed [SUM_W-1:0] sh;
      logic [SUM_W-1:0]        mag;
      sh  = s >>> k;
      mag = sh[SUM_W-1] ? (~sh + 1'b1) : sh;
      return (mag > OUT_MAX) ? OUT_MAX[PIX_W-1:0] : mag[PIX_W-1:0];
   endfunction

endpackage

@@ rtl/rgbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module rgbc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rgbc_window.sv @@
// Frame position counters, two-row line store and 3x3 window with zero padding.
// Depends on rgbc_pkg and rgbc_ram; registers the masked taps of each output pixel.
module rgbc_window #(
   parameter int IMG_WIDTH  = rgbc_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = rgbc_pkg::IMG_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   flush,
   input  rgbc_pkg::rgb_type      pixel,
   output logic                   produce,
   output rgbc_pkg::rgb_taps_type taps,
   output rgbc_pkg::meta_type     meta
);

   localparam int PIXELS = IMG_WIDTH * IMG_HEIGHT;
   localparam int TOTAL  = PIXELS + IMG_WIDTH + 1;
   localparam int CNT_W  = $clog2(TOTAL);
   localparam int XW     = $clog2(IMG_WIDTH);
   localparam int YW     = $clog2(IMG_HEIGHT);
   localparam int RGB_W  = rgbc_pkg::RGB_W;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [XW-1:0]    pc_ff, pc_in;
   logic [YW-1:0]    pr_ff, pr_in;
   rgbc_pkg::rgb_type win_ff [6];
   rgbc_pkg::rgb_type win_in [6];
   rgbc_pkg::rgb_taps_type taps_ff, taps_in;
   rgbc_pkg::meta_type     meta_ff, meta_in;

   rgbc_pkg::rgb_type cur [3];
   logic [2*RGB_W-1:0] line_rd;
   logic pix_phase, step, wrap, x_wrap, pc_wrap;
   logic row_ok [3];
   logic col_ok [3];

   rgbc_ram #(
      .WIDTH (2 * RGB_W),
      .DEPTH (IMG_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (x_ff),
      .wr_data ({cur[1], cur[2]}),
      .rd_addr (x_in),
      .rd_data (line_rd)
   );

   always_comb begin
      pix_phase = cnt_ff < CNT_W'(PIXELS);
      step      = accept && !(flush && pix_phase);
      produce   = step && (cnt_ff >= CNT_W'(IMG_WIDTH + 1));
      wrap      = cnt_ff == CNT_W'(TOTAL - 1);
      x_wrap    = x_ff == XW'(IMG_WIDTH - 1);
      pc_wrap   = pc_ff == XW'(IMG_WIDTH - 1);

      cur[0] = line_rd[2*RGB_W-1:RGB_W];
      cur[1] = line_rd[RGB_W-1:0];
      cur[2] = pix_phase ? pixel : '0;

      cnt_in = cnt_ff;
      x_in   = x_ff;
      if (step) begin
         cnt_in = wrap ? '0 : cnt_ff + 1'b1;
         x_in   = (wrap || x_wrap) ? '0 : x_ff + 1'b1;
      end

      pc_in = pc_ff;
      pr_in = pr_ff;
      if (produce) begin
         pc_in = pc_wrap ? '0 : pc_ff + 1'b1;
         if (pc_wrap) begin
            pr_in = (pr_ff == YW'(IMG_HEIGHT - 1)) ? '0 : pr_ff + 1'b1;
         end
      end

      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (step) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i]     = win_ff[3 + i];
            win_in[3 + i] = cur[i];
         end
      end

      row_ok[0] = pr_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = pr_ff != YW'(IMG_HEIGHT - 1);
      col_ok[0] = pc_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = !pc_wrap;

      for (int i = 0; i < 3; i++) begin
         taps_in[3*i]     = (row_ok[i] && col_ok[0]) ? win_ff[i]     : '0;
         taps_in[3*i + 1] = (row_ok[i] && col_ok[1]) ? win_ff[3 + i] : '0;
         taps_in[3*i + 2] = (row_ok[i] && col_ok[2]) ? cur[i]        : '0;
      end

      meta_in.row  = rgbc_pkg::POS_W'(pr_ff);
      meta_in.col  = rgbc_pkg::POS_W'(pc_ff);
      meta_in.last = (pr_ff == YW'(IMG_HEIGHT - 1)) && pc_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         x_ff   <= '0;
         pc_ff  <= '0;
         pr_ff  <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         x_ff   <= x_in;
         pc_ff  <= pc_in;
         pr_ff  <= pr_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         taps_ff <= taps_in;
         meta_ff <= meta_in;
      end
   end

   assign taps = taps_ff;
   assign meta = meta_ff;

endmodule

@@ rtl/rgbc_lane.sv @@
// One color lane: nine signed products, their sum, and the shifted, clamped magnitude.
// Depends on rgbc_pkg; stage enables come from the top-level pipeline control.
module rgbc_lane (
   input  logic                                 clock,
   input  rgbc_pkg::stage_en_type               en,
   input  rgbc_pkg::chan_taps_type              taps,
   input  logic [rgbc_pkg::KERNEL_W-1:0]        kernel,
   input  logic [rgbc_pkg::SHIFT_W-1:0]         shift,
   output logic [rgbc_pkg::PIX_W-1:0]           result
);

   localparam int TAPS     = rgbc_pkg::TAPS;
   localparam int PROD_W   = rgbc_pkg::PROD_W;
   localparam int SUM_W    = rgbc_pkg::SUM_W;
   localparam int WEIGHT_W = rgbc_pkg::WEIGHT_W;

   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic signed [PROD_W-1:0] prod_in [TAPS];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   always_comb begin
      logic signed [PROD_W-1:0] a;
      logic signed [PROD_W-1:0] b;
      logic [WEIGHT_W-1:0]      w;
      for (int t = 0; t < TAPS; t++) begin
         w = kernel[WEIGHT_W*t +: WEIGHT_W];
         a = signed'({{(PROD_W - rgbc_pkg::PIX_W){1'b0}}, taps[t]});
         b = signed'({{(PROD_W - WEIGHT_W){w[WEIGHT_W-1]}}, w});
         prod_in[t] = a * b;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int t = 0; t < TAPS; t++) begin
         sum_in = sum_in + SUM_W'(prod_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         for (int t = 0; t < TAPS; t++) begin
            prod_ff[t] <= prod_in[t];
         end
      end
      if (en.sum) begin
         sum_ff <= sum_in;
      end
   end

   assign result = rgbc_pkg::finish_sum(sum_ff, shift);

endmodule

@@ rtl/rgb_conv3x3_filter.sv @@
// Top level of the RGB 3x3 filter: register port, pipeline control, lanes and merge.
// Depends on rgbc_pkg, rgbc_window and rgbc_lane.
//
// Pixels enter on the req_ stream in raster order, one beat each; req_tuser set
// marks a flush tick. Each channel is filtered with the same signed 3x3 kernel,
// borders padded with zeros; each sum is shifted right arithmetically, made
// absolute and clamped to 255. The result for pixel (r,c) leaves on the rsp_
// stream after the beat of pixel (r+1,c+1); after the last pixel, IMG_WIDTH+1
// flush beats drive out the rest, and rsp_tlast marks the last result.
// Flush beats within the pixel phase are dropped; pixels in the flush phase act
// as flush beats. Throughput is one beat per cycle while rsp_tready stays high;
// each result passes the tap, product, sum and output registers in that order.
// Each stage holds only while the stage after it is full and stalled, so a
// stalled receiver fills the bubbles before req_tready drops. Reset empties the
// pipeline, restarts the frame and loads the default kernel (all ones) and a
// shift of 3. The kernel and shift registers sit at csr_ addresses 0 and 8.
module rgb_conv3x3_filter #(
   parameter int IMG_WIDTH  = rgbc_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = rgbc_pkg::IMG_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // red_in, green_in, blue_in
   input  logic                                req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,  // red, green, blue, row, col, pad
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rgbc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rgbc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rgbc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PIX_W = rgbc_pkg::PIX_W;

   logic [rgbc_pkg::KERNEL_W-1:0] kernel_ff, kernel_in;
   logic [rgbc_pkg::SHIFT_W-1:0]  shift_ff, shift_in;
   logic csr_wr, csr_reg;

   logic t_valid_ff, p_valid_ff, s_valid_ff, o_valid_ff;
   logic t_ready, p_ready, s_ready, o_ready;
   logic accept, produce;

   rgbc_pkg::rgb_taps_type taps;
   rgbc_pkg::meta_type     meta_t, meta_p_ff, meta_s_ff;
   rgbc_pkg::stage_en_type lane_en;
   rgbc_pkg::chan_taps_type lane_taps [rgbc_pkg::CHANNELS];
   logic [PIX_W-1:0] lane_out [rgbc_pkg::CHANNELS];
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_reg    = csr_paddr[3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      kernel_in = kernel_ff;
      shift_in  = shift_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            rgbc_pkg::REG_KERNEL: kernel_in = csr_pwdata[rgbc_pkg::KERNEL_W-1:0];
            rgbc_pkg::REG_SHIFT:  shift_in  = csr_pwdata[rgbc_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
      unique case (csr_reg)
         rgbc_pkg::REG_KERNEL: csr_prdata = rgbc_pkg::CSR_DATA_W'(kernel_ff);
         rgbc_pkg::REG_SHIFT:  csr_prdata = rgbc_pkg::CSR_DATA_W'(shift_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= rgbc_pkg::KERNEL_RESET;
         shift_ff  <= rgbc_pkg::SHIFT_RESET;
      end else begin
         kernel_ff <= kernel_in;
         shift_ff  <= shift_in;
      end
   end

   // pipeline control
   assign o_ready    = !o_valid_ff || rsp_tready;
   assign s_ready    = !s_valid_ff || o_ready;
   assign p_ready    = !p_valid_ff || s_ready;
   assign t_ready    = !t_valid_ff || p_ready;
   assign req_tready = t_ready;
   assign accept     = req_tvalid && t_ready;
   assign lane_en    = '{prod: p_ready, sum: s_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (t_ready) begin
            t_valid_ff <= produce;
         end
         if (p_ready) begin
            p_valid_ff <= t_valid_ff;
         end
         if (s_ready) begin
            s_valid_ff <= p_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= s_valid_ff;
         end
      end
   end

   rgbc_window #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .flush   (req_tuser),
      .pixel   ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .produce (produce),
      .taps    (taps),
      .meta    (meta_t)
   );

   for (genvar ch = 0; ch < rgbc_pkg::CHANNELS; ch++) begin : g_lane
      always_comb begin
         for (int t = 0; t < rgbc_pkg::TAPS; t++) begin
            lane_taps[ch][t] = taps[t][rgbc_pkg::RGB_W-1-PIX_W*ch -: PIX_W];
         end
      end

      rgbc_lane u_lane (
         .clock  (clock),
         .en     (lane_en),
         .taps   (lane_taps[ch]),
         .kernel (kernel_ff),
         .shift  (shift_ff),
         .result (lane_out[ch])
      );
   end

   // merge lanes and position into the output beat
   assign rsp_data_in = {4'b0000, meta_s_ff.col, meta_s_ff.row,
                         lane_out[2], lane_out[1], lane_out[0]};

   always_ff @(posedge clock) begin
      if (p_ready) begin
         meta_p_ff <= meta_t;
      end
      if (s_ready) begin
         meta_s_ff <= meta_p_ff;
      end
      if (o_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= meta_s_ff.last;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/rgb_conv3x3_filter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_conv3x3_filter: streams the upper rows of an RGB frame under
// several kernel settings, predicts every filtered pixel in-bench and compares beat by beat.
// Depends on rgbc_pkg and the RTL.
module rgb_conv3x3_filter_tb;

   localparam int IMG_W   = rgbc_pkg::IMG_WIDTH_DEF;
   localparam int IMG_H   = rgbc_pkg::IMG_HEIGHT_DEF;
   localparam int N_PIX   = IMG_W * IMG_H;
   localparam int N_TOTAL = N_PIX + IMG_W + 1;

   localparam logic [rgbc_pkg::CSR_ADDR_W-1:0] ADDR_KERNEL = {rgbc_pkg::REG_KERNEL, 3'b000};
   localparam logic [rgbc_pkg::CSR_ADDR_W-1:0] ADDR_SHIFT  = {rgbc_pkg::REG_SHIFT, 3'b000};

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;

   typedef struct packed {
      logic       tick;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } frame_item_type;

   typedef struct packed {
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
      logic [rgbc_pkg::POS_W-1:0] row;
      logic [rgbc_pkg::POS_W-1:0] col;
      logic                       last;
   } filt_px_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [23:0]                     req_tdata   = '0;
   logic                            req_tuser   = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [39:0]                     rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [rgbc_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [rgbc_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [rgbc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   rgb_conv3x3_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [rgbc_pkg::KERNEL_W-1:0] coef_kernel = rgbc_pkg::KERNEL_RESET;
   logic [rgbc_pkg::SHIFT_W-1:0]  coef_shift  = rgbc_pkg::SHIFT_RESET;
   logic [23:0]                   line_mem [2][IMG_W];
   logic [23:0]                   win_col [6];
   int                            frame_pos = 0;

   frame_item_type frame_items_q [$];
   filt_px_type    filtered_q [$];

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit hold_done = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int pixels_queued = 0;
   int beats_in = 0;
   int results_seen = 0;
   int settings_used = 1;
   int fail_count = 0;

   initial begin
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win_col[i]) win_col[i] = '0;
   end

   function automatic logic [7:0] scale_clamp(int s);
      int v;
      v = s >>> coef_shift;
      if (v < 0) v = -v;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Advance the window by one beat; return 1 when the beat completes an output pixel.
   function automatic bit conv_step(input logic tick, input logic [23:0] pixel,
                                    output filt_px_type res);
      int n, x, p, r, c, tr, tc, w, i, j, ch;
      int acc [3];
      logic [23:0] cur [3];
      logic [23:0] pix;
      bit hit;
      n = frame_pos;
      x = n % IMG_W;
      hit = 1'b0;
      res = '0;
      if (tick && n < N_PIX) return 1'b0;
      if (n >= N_PIX) pixel = '0;
      cur[0] = line_mem[0][x];
      cur[1] = line_mem[1][x];
      cur[2] = pixel;
      if (n >= IMG_W + 1 && n - IMG_W - 1 < N_PIX) begin
         p = n - IMG_W - 1;
         r = p / IMG_W;
         c = p % IMG_W;
         acc = '{0, 0, 0};
         for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
               tr = r + i - 1;
               tc = c + j - 1;
               if (tr >= 0 && tr < IMG_H && tc >= 0 && tc < IMG_W) begin
                  pix = (j == 0) ? win_col[i] : (j == 1) ? win_col[3 + i] : cur[i];
                  w = int'($signed(coef_kernel[rgbc_pkg::WEIGHT_W * (3 * i + j) +:
                                               rgbc_pkg::WEIGHT_W]));
                  for (ch = 0; ch < 3; ch++)
                     acc[ch] += int'(pix[16 - 8 * ch +: 8]) * w;
               end
            end
         end
         res.red   = scale_clamp(acc[0]);
         res.green = scale_clamp(acc[1]);
         res.blue  = scale_clamp(acc[2]);
         res.row   = r[rgbc_pkg::POS_W-1:0];
         res.col   = c[rgbc_pkg::POS_W-1:0];
         res.last  = (p == N_PIX - 1);
         hit = 1'b1;
      end
      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = cur[0];
      win_col[4] = cur[1];
      win_col[5] = cur[2];
      line_mem[0][x] = cur[1];
      line_mem[1][x] = cur[2];
      frame_pos = (n + 1 >= N_TOTAL) ? 0 : n + 1;
      return hit;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // sender: hold a beat until taken, then idle for the drawn gap
   always @(negedge clock) begin
      frame_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (frame_items_q.size() > 0) begin
            item = frame_items_q.pop_front();
            req_tuser  <= item.tick;
            req_tdata  <= {item.blue, item.green, item.red};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: one long hold-off once, otherwise a drawn wait per beat
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (results_seen >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_taken) begin
            if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      filt_px_type res, want, got;
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (req_taken) begin
         beats_in++;
         if (conv_step(req_tuser, {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}, res))
            filtered_q.push_back(res);
      end
      if (rsp_taken) begin
         got.red   = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue  = rsp_tdata[23:16];
         got.row   = rsp_tdata[29:24];
         got.col   = rsp_tdata[35:30];
         got.last  = rsp_tlast;
         results_seen++;
         if (filtered_q.size() == 0) begin
            $error("result beat with none pending: row %0d col %0d", got.row, got.col);
            fail_count++;
         end else begin
            want = filtered_q.pop_front();
            check_field("red_out", want.red, got.red);
            check_field("green_out", want.green, got.green);
            check_field("blue_out", want.blue, got.blue);
            check_field("out_row", 8'(want.row), 8'(got.row));
            check_field("out_col", 8'(want.col), 8'(got.col));
            check_field("frame_last", 8'(want.last), 8'(got.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results pending",
                  QUIET_LIMIT, filtered_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_item(logic tick, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      frame_items_q.push_back('{tick: tick, red: r, green: g, blue: b});
      if (!tick) pixels_queued++;
   endtask

   task automatic queue_pixels(int upto);
      while (pixels_queued < upto) begin
         if ($urandom_range(0, 31) == 0)
            push_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
         push_item(1'b0, rand_byte(), rand_byte(), rand_byte());
      end
   endtask

   task automatic settle();
      while (frame_items_q.size() != 0 || req_tvalid || filtered_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [rgbc_pkg::CSR_ADDR_W-1:0] addr,
                            logic [rgbc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_KERNEL)
         coef_kernel = value[rgbc_pkg::KERNEL_W-1:0];
      else
         coef_shift = value[rgbc_pkg::SHIFT_W-1:0];
   endtask

   task automatic apply_setting(logic [rgbc_pkg::CSR_DATA_W-1:0] kernel,
                                logic [rgbc_pkg::CSR_DATA_W-1:0] shift);
      settle();
      csr_write(ADDR_KERNEL, kernel);
      csr_write(ADDR_SHIFT, shift);
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(1'b0, 8'd0, 8'd0, 8'd0);
      push_item(1'b0, 8'd255, 8'd255, 8'd255);
      push_item(1'b1, 8'd255, 8'd255, 8'd255);
      push_item(1'b0, 8'hAA, 8'h55, 8'hFF);
      push_item(1'b0, 8'h55, 8'hAA, 8'h00);
      push_item(1'b0, 8'd255, 8'd0, 8'd0);
      push_item(1'b0, 8'd0, 8'd255, 8'd0);
      push_item(1'b0, 8'd0, 8'd0, 8'd255);
      push_item(1'b1, 8'd0, 8'd0, 8'd0);
      push_item(1'b0, 8'd1, 8'd2, 8'd128);
      push_item(1'b0, 8'd254, 8'd127, 8'd64);
      push_item(1'b0, 8'd255, 8'd255, 8'd255);
      push_item(1'b0, 8'd255, 8'd255, 8'd255);
      queue_pixels(500);

      apply_setting({19'd0, {rgbc_pkg::TAPS{5'b10000}}}, 64'd0);
      queue_pixels(900);
      apply_setting({19'd0, {rgbc_pkg::TAPS{5'b01111}}}, 64'd15);
      queue_pixels(1250);
      apply_setting(64'd0, 64'd4);
      queue_pixels(1550);
      apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF7);
      queue_pixels(1880);
      settle();
      repeat (20) @(posedge clock);

      $display("covered %0d input beats and %0d filtered pixels over %0d kernel settings",
               beats_in, results_seen, settings_used);
      $display("with stray flush beats, receiver stalls and one long hold-off");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
